[design/error_diffusion_pixel_quantizer_core_assert.svh]
// Assertion macros used by the error diffusion serializer RTL.
`ifndef ERROR_DIFFUSION_PIXEL_QUANTIZER_CORE_ASSERT_SVH
`define ERROR_DIFFUSION_PIXEL_QUANTIZER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define EDPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edpq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EDPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edpq assertion failed");

`else

`define EDPQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define EDPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/edpq_pkg.sv]
// Shared types and constants of the error diffusion pixel quantizer.
package edpq_pkg;

    // Fixed field widths.
    localparam int CHAN_MAX   = 4;
    localparam int IDX_W      = 2;
    localparam int LEVEL_W    = 16;
    localparam int ERR_W      = 34;
    localparam int IN_W       = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Output ranges as shift amounts: range = (1 << bits) - 1.
    localparam int RANGE_NARROW_BITS = 8;
    localparam int RANGE_WIDE_BITS   = 16;
    localparam logic [LEVEL_W-1:0] RANGE_NARROW = 16'h00FF;
    localparam logic [LEVEL_W-1:0] RANGE_WIDE   = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_OUTPUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 1'd1;

    typedef logic [LEVEL_W-1:0]      t_level;
    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic signed [IN_W-1:0]  t_chan;
    typedef logic [CHAN_MAX-1:0]     t_mask;
    typedef logic [IDX_W-1:0]        t_idx;

    // Hand-off of one quantized pixel to the serializer.
    typedef struct packed {
        logic  load;
        t_mask mask;
    } t_px_load;

endpackage

[design/edpq_quant.sv]
// Quantizer of one channel: scale, add carried error, clamp, round, new error.
module edpq_quant #(
    parameter int FRAC_BITS = 16
) (
    input  edpq_pkg::t_chan  i_chan,
    input  edpq_pkg::t_err   i_err,
    input  logic             i_wide,
    output edpq_pkg::t_level o_level,
    output edpq_pkg::t_err   o_err
);
    import edpq_pkg::*;

    // Wide enough for the corrected sum and for the full-scale level.
    localparam int CW = (FRAC_BITS + 18 > 37) ? FRAC_BITS + 18 : 37;

    logic signed [CW-1:0] s_chan;
    logic signed [CW-1:0] s_prod;
    logic signed [CW-1:0] s_corr;
    logic signed [CW-1:0] s_top;
    logic signed [CW-1:0] s_clamped;
    logic signed [CW-1:0] s_rnd;
    logic signed [CW-1:0] s_scaled;
    logic signed [CW-1:0] s_diff;
    logic [CW-ERR_W:0]    s_hi;
    t_level               s_range;

    // Scaling by 2^k - 1 is a shift and a subtract.
    assign s_chan  = CW'(i_chan);
    assign s_prod  = i_wide ? (s_chan <<< RANGE_WIDE_BITS) - s_chan
                            : (s_chan <<< RANGE_NARROW_BITS) - s_chan;
    assign s_corr  = s_prod + CW'(i_err);
    assign s_range = i_wide ? RANGE_WIDE : RANGE_NARROW;
    assign s_top   = $signed({{(CW-LEVEL_W){1'b0}}, s_range} << FRAC_BITS);

    // Clamp to zero..full scale, then round half up.
    always_comb begin
        if (s_corr < 0) begin
            s_clamped = '0;
        end else if (s_corr > s_top) begin
            s_clamped = s_top;
        end else begin
            s_clamped = s_corr;
        end
    end

    assign s_rnd   = s_clamped + (CW'(1) <<< (FRAC_BITS - 1));
    assign o_level = s_rnd[FRAC_BITS+LEVEL_W-1:FRAC_BITS];

    // The residual becomes the new carried error, saturated to its register.
    assign s_scaled = $signed({{(CW-LEVEL_W-FRAC_BITS){1'b0}}, o_level,
                               {FRAC_BITS{1'b0}}});
    assign s_diff   = s_corr - s_scaled;
    assign s_hi     = s_diff[CW-1:ERR_W-1];

    always_comb begin
        if ((&s_hi) || !(|s_hi)) begin
            o_err = s_diff[ERR_W-1:0];
        end else if (s_diff[CW-1]) begin
            o_err = {1'b1, {(ERR_W-1){1'b0}}};
        end else begin
            o_err = {1'b0, {(ERR_W-1){1'b1}}};
        end
    end

endmodule

[design/edpq_serializer.sv]
// Holds a quantized pixel, emits enabled channels one a cycle if unstalled.
`include "error_diffusion_pixel_quantizer_core_assert.svh"

module edpq_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  edpq_pkg::t_px_load i_load,
    input  edpq_pkg::t_level   i_levels [edpq_pkg::CHAN_MAX],
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output edpq_pkg::t_level   o_level,
    output edpq_pkg::t_idx     o_chan_index,
    output logic               o_pixel_last
);
    import edpq_pkg::*;

    t_mask  r_rem;
    t_level r_levels [CHAN_MAX];
    logic   r_out_valid;
    t_level r_out_level;
    t_idx   r_out_idx;
    logic   r_out_last;

    t_mask  n_rem;
    t_idx   s_sel;
    logic   s_found;
    logic   s_out_free;

    // Lowest pending channel goes out next.
    always_comb begin
        s_sel   = '0;
        s_found = 1'b0;
        for (int j = CHAN_MAX - 1; j >= 0; j--) begin
            if (r_rem[j]) begin
                s_sel   = IDX_W'(j);
                s_found = 1'b1;
            end
        end
        n_rem = r_rem & ~(t_mask'(1) << s_sel);
    end

    assign s_out_free = !r_out_valid || !i_out_stall;
    assign o_ready    = (r_rem == '0) || (s_out_free && (n_rem == '0));

    // Pending channel set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load.load) begin
            r_rem <= i_load.mask;
        end else if (s_out_free && s_found) begin
            r_rem <= n_rem;
        end
    end

    // Pixel levels.
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_levels <= i_levels;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_free && s_found) begin
            r_out_level <= r_levels[s_sel];
            r_out_idx   <= s_sel;
            r_out_last  <= (n_rem == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_out_level;
    assign o_chan_index = r_out_idx;
    assign o_pixel_last = r_out_last;

    // A result that is not the last of its pixel leaves channels pending.
    `EDPQ_ASSERT_NOW(a_more_pending, i_clk, i_rst_n,
        r_out_valid && !i_out_stall && !r_out_last, r_rem != '0)
    // Pending channels fill an empty output register at once.
    `EDPQ_ASSERT_NEXT(a_fill_output, i_clk, i_rst_n,
        (r_rem != '0) && !r_out_valid, r_out_valid)
    // Channels of one pixel leave in rising index order without a gap.
    `EDPQ_ASSERT_NEXT(a_index_order, i_clk, i_rst_n,
        r_out_valid && !i_out_stall && !r_out_last,
        r_out_valid && (r_out_idx > $past(r_out_idx)))

endmodule

[design/error_diffusion_pixel_quantizer_core.sv]
// Top level of the one-dimensional error diffusion pixel quantizer.
//
// Input channel: one pixel per item, four signed Q2.16 channels and a
// strand-start flag, taken when i_in_valid is high and o_in_stall is low.
// Output channel: one item per enabled channel, in channel order, with the
// quantized level, the channel index and a flag on the last one of a pixel.
// An item is delivered when o_out_valid is high and i_out_stall is low.
// Configuration is a write port: i_cfg_we with i_cfg_index and i_cfg_data.
// A pixel passes the input register, the pending channel set of the serializer
// and its output register, in that order. The single result channel emits one
// item a cycle while the receiver does not stall, so a pixel holds the block
// while its enabled channels go out; a pixel with none enabled passes too.
// The carried error is updated when a pixel leaves the input register, so
// pixels follow back to back without waiting on each other.
// Reset clears the carried error, selects the 8-bit range and enables all
// channels; no clearing pass is needed.
// When the receiver stalls, the output register holds, the pixel behind it
// waits, and o_in_stall rises once the input register is occupied as well.
module error_diffusion_pixel_quantizer_core #(
    parameter int CHANNELS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [edpq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [edpq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  edpq_pkg::t_chan                     i_chan0,
    input  edpq_pkg::t_chan                     i_chan1,
    input  edpq_pkg::t_chan                     i_chan2,
    input  edpq_pkg::t_chan                     i_chan3,
    input  logic                                i_strand_start,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output edpq_pkg::t_level                    o_level,
    output edpq_pkg::t_idx                      o_chan_index,
    output logic                                o_pixel_last
);
    import edpq_pkg::*;

    localparam t_mask CHAN_EN = t_mask'((1 << CHANNELS) - 1);

    logic     r_wide;
    t_mask    r_mask;
    logic     r_in_valid;
    t_chan    r_chan [CHANNELS];
    logic     r_start;
    t_err     r_err [CHANNELS];

    t_chan    s_chan_in [CHAN_MAX];
    t_level   s_level [CHAN_MAX];
    t_err     s_new_err [CHANNELS];
    logic     s_px_ready;
    logic     s_advance;
    t_px_load s_load;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
            r_mask <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDE_OUTPUT:  r_wide <= i_cfg_data[0];
                CFG_CHANNEL_MASK: r_mask <= i_cfg_data[CHAN_MAX-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    assign s_chan_in[0] = i_chan0;
    assign s_chan_in[1] = i_chan1;
    assign s_chan_in[2] = i_chan2;
    assign s_chan_in[3] = i_chan3;

    assign o_in_stall = r_in_valid && !s_px_ready;
    assign s_advance  = r_in_valid && s_px_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            for (int j = 0; j < CHANNELS; j++) begin
                r_chan[j] <= s_chan_in[j];
            end
            r_start <= i_strand_start;
        end
    end

    // One quantizer per channel; the strand start sees a zero error.
    for (genvar g = 0; g < CHAN_MAX; g++) begin : g_chan
        if (g < CHANNELS) begin : g_on
            edpq_quant #(
                .FRAC_BITS (FRAC_BITS)
            ) u_quant (
                .i_chan  (r_chan[g]),
                .i_err   (r_start ? t_err'(0) : r_err[g]),
                .i_wide  (r_wide),
                .o_level (s_level[g]),
                .o_err   (s_new_err[g])
            );
        end else begin : g_off
            assign s_level[g] = '0;
        end
    end

    // Carried error, updated as the pixel moves to the serializer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CHANNELS; j++) begin
                r_err[j] <= '0;
            end
        end else if (s_advance) begin
            for (int j = 0; j < CHANNELS; j++) begin
                r_err[j] <= s_new_err[j];
            end
        end
    end

    assign s_load.load = s_advance;
    assign s_load.mask = r_mask & CHAN_EN;

    edpq_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (s_load),
        .i_levels     (s_level),
        .o_ready      (s_px_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_level      (o_level),
        .o_chan_index (o_chan_index),
        .o_pixel_last (o_pixel_last)
    );

endmodule

[dv/error_diffusion_pixel_quantizer_core_tb.sv]
// Self-checking testbench for the error diffusion pixel quantizer core.
module error_diffusion_pixel_quantizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edpq_pkg::*;

    localparam int CHAN_COUNT     = 4;
    localparam int FRAC           = 16;
    localparam int IDLE_PCT       = 38;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_PIXELS   = 34;
    localparam longint ERR_HI     = (longint'(1) <<< (ERR_W - 1)) - 1;
    localparam longint ERR_LO     = -(longint'(1) <<< (ERR_W - 1));

    // One pixel as driven on the input channel.
    typedef struct packed {
        logic [CHAN_MAX-1:0][IN_W-1:0] chan;
        logic                          strand_start;
    } t_pixel;

    // One quantized channel value as expected on the output channel.
    typedef struct packed {
        t_level level;
        t_idx   chan_index;
        logic   pixel_last;
    } t_level_item;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_stall;
    t_chan            i_chan0        = '0;
    t_chan            i_chan1        = '0;
    t_chan            i_chan2        = '0;
    t_chan            i_chan3        = '0;
    logic             i_strand_start = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall    = 1'b0;
    t_level           o_level;
    t_idx             o_chan_index;
    logic             o_pixel_last;

    t_pixel      pending_pixels[$];
    t_level_item expected_levels[$];
    t_pixel      driven_pixel;
    t_level_item want;
    longint      carried_err[CHAN_MAX];
    logic        mode_wide;
    t_mask       mode_mask;
    bit          calm;
    int          fail_count;
    int          pixels_taken;
    int          levels_seen;
    int          settings_used;
    int          quiet_cycles;

    error_diffusion_pixel_quantizer_core #(
        .CHANNELS  (CHAN_COUNT),
        .FRAC_BITS (FRAC)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_chan0        (i_chan0),
        .i_chan1        (i_chan1),
        .i_chan2        (i_chan2),
        .i_chan3        (i_chan3),
        .i_strand_start (i_strand_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_level        (o_level),
        .o_chan_index   (o_chan_index),
        .o_pixel_last   (o_pixel_last)
    );

    // Clock generation.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Prints one mismatch line and counts it.
    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Quantizes one pixel, updates the carried error and queues the levels
    // of the enabled channels in channel order.
    function automatic void quantize_pixel(input t_pixel px);
        longint      span;
        longint      top;
        longint      corrected;
        longint      clipped;
        longint      lvl;
        longint      err;
        int          last_j;
        t_level_item item;
        span   = mode_wide ? longint'(RANGE_WIDE) : longint'(RANGE_NARROW);
        top    = span <<< FRAC;
        last_j = -1;
        for (int j = 0; j < CHAN_COUNT; j++) begin
            if (mode_mask[j]) last_j = j;
        end
        if (px.strand_start) begin
            for (int j = 0; j < CHAN_MAX; j++) carried_err[j] = 0;
        end
        for (int j = 0; j < CHAN_COUNT; j++) begin
            corrected = longint'($signed(px.chan[j])) * span + carried_err[j];
            clipped   = corrected;
            if (clipped < 0) clipped = 0;
            if (clipped > top) clipped = top;
            lvl = (clipped + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            err = corrected - (lvl <<< FRAC);
            if (err > ERR_HI) err = ERR_HI;
            if (err < ERR_LO) err = ERR_LO;
            carried_err[j] = err;
            if (mode_mask[j]) begin
                item.level      = t_level'(lvl);
                item.chan_index = t_idx'(j);
                item.pixel_last = (j == last_j);
                expected_levels.push_back(item);
            end
        end
    endfunction

    // Queues one directed pixel.
    task automatic queue_pixel(input int c0, input int c1, input int c2, input int c3,
                               input bit strand);
        t_pixel px;
        px.chan[0]      = c0[IN_W-1:0];
        px.chan[1]      = c1[IN_W-1:0];
        px.chan[2]      = c2[IN_W-1:0];
        px.chan[3]      = c3[IN_W-1:0];
        px.strand_start = strand;
        pending_pixels.push_back(px);
    endtask

    // Mostly in-range intensities, with extremes and full-width noise mixed in.
    function automatic logic [IN_W-1:0] random_intensity();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            case ($urandom_range(4))
                0:       return 18'h1FFFF;
                1:       return 18'h20000;
                2:       return 18'h08000;
                3:       return 18'h10000;
                default: return '0;
            endcase
        end
        if (pick < 28) return IN_W'($urandom());
        return IN_W'($urandom_range(65536));
    endfunction

    // Queues strands of pixels, each opened by a strand start; a few strands
    // carry random strand-start flags instead.
    task automatic queue_random(input int count);
        int     left;
        int     len;
        bit     broken;
        t_pixel px;
        left = count;
        while (left > 0) begin
            len    = $urandom_range(1, 12);
            broken = ($urandom_range(9) == 0);
            if (len > left) len = left;
            for (int k = 0; k < len; k++) begin
                for (int j = 0; j < CHAN_MAX; j++) px.chan[j] = random_intensity();
                px.strand_start = broken ? 1'($urandom_range(1)) : (k == 0);
                pending_pixels.push_back(px);
            end
            left -= len;
        end
    endtask

    // Writes both mode registers; only called while the block is idle.
    task automatic set_mode(input logic wide, input t_mask mask);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WIDE_OUTPUT;
        i_cfg_data  <= CFG_DATA_W'(wide);
        @(posedge i_clk);
        i_cfg_index <= CFG_CHANNEL_MASK;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_wide   = wide;
        mode_mask   = mask;
        settings_used++;
    endtask

    // Holds the sender until every queued pixel is taken and every expected
    // level has come out, then lets an empty-mask pixel finish.
    task automatic drain();
        while (pending_pixels.size() != 0 || i_in_valid || expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: takes the next pending pixel once the current one is gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                quantize_pixel(driven_pixel);
                pixels_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_pixels.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    driven_pixel    = pending_pixels.pop_front();
                    i_in_valid     <= 1'b1;
                    i_chan0        <= driven_pixel.chan[0];
                    i_chan1        <= driven_pixel.chan[1];
                    i_chan2        <= driven_pixel.chan[2];
                    i_chan3        <= driven_pixel.chan[3];
                    i_strand_start <= driven_pixel.strand_start;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall generator.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Output monitor: compares each level item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            levels_seen++;
            if (expected_levels.size() == 0) begin
                report($sformatf("unexpected item: level %0d channel %0d last %0b",
                                 o_level, o_chan_index, o_pixel_last));
            end else begin
                want = expected_levels.pop_front();
                if (o_level !== want.level)
                    report($sformatf("level %0d, expected %0d (channel %0d)",
                                     o_level, want.level, want.chan_index));
                if (o_chan_index !== want.chan_index)
                    report($sformatf("channel index %0d, expected %0d",
                                     o_chan_index, want.chan_index));
                if (o_pixel_last !== want.pixel_last)
                    report($sformatf("pixel last %0b, expected %0b (channel %0d)",
                                     o_pixel_last, want.pixel_last, want.chan_index));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        for (int j = 0; j < CHAN_MAX; j++) carried_err[j] = 0;
        mode_wide     = 1'b0;
        mode_mask     = 4'hF;
        calm          = 1'b0;
        fail_count    = 0;
        pixels_taken  = 0;
        levels_seen   = 0;
        settings_used = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset mode: extremes, exact half-way rounding and a carried error.
        queue_pixel(0, 0, 0, 0, 1'b1);
        queue_pixel(131071, -131072, 65536, 32768, 1'b1);
        queue_pixel(32768, 32768, 32768, 32768, 1'b1);
        queue_pixel(1, -1, 65535, 256, 1'b0);
        queue_pixel(100, 200, 300, 400, 1'b0);
        drain();

        // Wide range: drive the carried error into both saturation limits.
        set_mode(1'b1, 4'hF);
        queue_pixel(-131072, -131072, -131072, -131072, 1'b1);
        repeat (3) queue_pixel(-131072, -131072, -131072, -131072, 1'b0);
        queue_pixel(131071, 131071, 131071, 131071, 1'b1);
        repeat (3) queue_pixel(131071, 131071, 131071, 131071, 1'b0);
        queue_pixel(32768, 32768, 0, 65536, 1'b1);
        drain();

        // Empty mask still moves the error; a partial mask picks it up after.
        set_mode(1'b0, 4'h0);
        queue_pixel(50000, 12345, 40000, 777, 1'b1);
        queue_pixel(50000, 12345, 40000, 777, 1'b0);
        drain();
        set_mode(1'b0, 4'h6);
        queue_pixel(50000, 12345, 40000, 777, 1'b0);
        queue_pixel(-5, 70000, 1000, 65536, 1'b0);
        drain();

        // Random phases under changing modes; two run with no idling at all.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       set_mode(1'b0, 4'hF);
                1:       set_mode(1'b1, 4'h0);
                2:       set_mode(1'b1, 4'hF);
                default: set_mode(1'($urandom_range(1)), t_mask'($urandom_range(15)));
            endcase
            calm = (p == 3 || p == 4);
            queue_random(PHASE_PIXELS);
            drain();
        end
        calm = 1'b0;

        while (expected_levels.size() != 0) begin
            want = expected_levels.pop_front();
            report($sformatf("level %0d for channel %0d never came out",
                             want.level, want.chan_index));
        end
        $display("Run covered %0d pixels and %0d channel levels over %0d mode settings,",
                 pixels_taken, levels_seen, settings_used);
        $display("both output ranges, empty and partial masks, and saturated error.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
